[rtl/core/bcpg_pkg.sv]
// shared widths and register indexes of the bezier point generator
package bcpg_pkg;

    localparam int IDX_W     = 10;
    localparam int COORD_W   = 16;
    localparam int ACC_W     = 48;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd7;

endpackage

[rtl/core/bcpg_mul.sv]
// shared multiplier with registered product
module bcpg_mul
(
    input  logic                         clk,
    input  logic [bcpg_pkg::MUL_A_W-1:0] op_a,
    input  logic [bcpg_pkg::MUL_B_W-1:0] op_b,
    output logic [bcpg_pkg::ACC_W-1:0]   prod
);
    import bcpg_pkg::*;

    logic [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0] prod_next;

    assign prod_next = ACC_W'(op_a) * ACC_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[rtl/core/bcpg_div.sv]
// division by steps cubed through a reciprocal: operand shaping and remainder correction
module bcpg_div
#(
    parameter int STEPS = 1000
)
(
    input  logic [bcpg_pkg::ACC_W-1:0]    num,
    input  logic [bcpg_pkg::ACC_W-1:0]    prod,
    input  logic [bcpg_pkg::ACC_W-1:0]    rem,
    input  logic [bcpg_pkg::COORD_W-1:0]  q_base,
    output logic [bcpg_pkg::MUL_A_W-1:0]  num_hi,
    output logic [bcpg_pkg::MUL_B_W-1:0]  recip,
    output logic [bcpg_pkg::MUL_A_W-1:0]  den,
    output logic [bcpg_pkg::COORD_W-1:0]  q_est,
    output logic [bcpg_pkg::COORD_W-1:0]  quot
);
    import bcpg_pkg::*;

    localparam logic [ACC_W-1:0] DEN = ACC_W'(STEPS) * ACC_W'(STEPS) * ACC_W'(STEPS);
    // numerator stays below 2^NUM_W since the weights sum to steps cubed
    localparam int DEN_W = $clog2(DEN + ACC_W'(1));
    localparam int NUM_W = COORD_W + DEN_W;
    localparam int SH    = (NUM_W > MUL_A_W) ? (NUM_W - MUL_A_W) : 0;
    // keeps the reciprocal within 15 bits; the estimate then falls short by at most 5
    localparam int K     = COORD_W - 2 + DEN_W - SH;
    localparam logic [ACC_W-1:0] RECIP_FULL = (ACC_W'(1) << (SH + K)) / DEN;
    localparam logic [ACC_W-1:0] DEN2 = DEN + DEN;
    localparam logic [ACC_W-1:0] DEN3 = DEN2 + DEN;
    localparam logic [ACC_W-1:0] DEN4 = DEN3 + DEN;
    localparam logic [ACC_W-1:0] DEN5 = DEN4 + DEN;

    logic [2:0] fix;

    assign num_hi = MUL_A_W'(num >> SH);
    assign recip  = MUL_B_W'(RECIP_FULL);
    assign den    = MUL_A_W'(DEN);
    assign q_est  = COORD_W'(prod >> K);

    always_comb
    begin
        priority if (rem >= DEN5)
        begin
            fix = 3'd5;
        end
        else if (rem >= DEN4)
        begin
            fix = 3'd4;
        end
        else if (rem >= DEN3)
        begin
            fix = 3'd3;
        end
        else if (rem >= DEN2)
        begin
            fix = 3'd2;
        end
        else if (rem >= DEN)
        begin
            fix = 3'd1;
        end
        else
        begin
            fix = 3'd0;
        end
    end

    assign quot = q_base + COORD_W'(fix);

endmodule

[rtl/core/cubic_bezier_point_generator.sv]
// cubic bezier point generator: sequencer, weight and product schedule, result register
// an input beat runs 20 steps on the shared multiplier (weights, weighted control points,
// reciprocal quotient estimates and their back products, correction), then loads the output
// register once it is free; the sequencer waits in S_DONE while the output register stays full
// in_ready is high only while the sequencer is idle, which it is again once a point is loaded
// reset: rst_n clears the control points to 0, the step index to 0 and all valid flags
module cubic_bezier_point_generator
#(
    parameter int STEPS = 1000
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcpg_pkg::COORD_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            restart,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bcpg_pkg::COORD_W-1:0]    point_x,
    output logic [bcpg_pkg::COORD_W-1:0]    point_y,
    output logic                            last_point
);
    import bcpg_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DONE = 3'd2;

    localparam logic [IDX_W-1:0] STEPS_I = IDX_W'(STEPS);
    localparam logic [4:0]       STEP_LAST = 5'd19;

    logic [COORD_W-1:0] cfg_reg [NUM_REGS];

    logic [2:0]         state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic [IDX_W-1:0]   step_index_reg, step_index_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   r_reg, r_next;
    logic               last_reg, last_next;
    logic [19:0]        ii_reg, ii_next;
    logic [19:0]        rr_reg, rr_next;
    logic [MUL_A_W-1:0] w0_reg, w0_next;
    logic [MUL_A_W-1:0] w1_reg, w1_next;
    logic [MUL_A_W-1:0] w2_reg, w2_next;
    logic [MUL_A_W-1:0] w3_reg, w3_next;
    logic [ACC_W-1:0]   accx_reg, accx_next;
    logic [ACC_W-1:0]   accy_reg, accy_next;
    logic [COORD_W-1:0] qex_reg, qex_next;
    logic [COORD_W-1:0] qey_reg, qey_next;
    logic [ACC_W-1:0]   remx_reg, remx_next;
    logic [ACC_W-1:0]   remy_reg, remy_next;
    logic [COORD_W-1:0] qx_reg, qx_next;
    logic [COORD_W-1:0] px_reg, px_next;
    logic [COORD_W-1:0] py_reg, py_next;
    logic               plast_reg, plast_next;
    logic               ovalid_reg, ovalid_next;

    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    logic [ACC_W-1:0]   prod;
    logic [ACC_W-1:0]   div_num;
    logic [ACC_W-1:0]   div_rem;
    logic [COORD_W-1:0] div_qbase;
    logic [MUL_A_W-1:0] num_hi;
    logic [MUL_B_W-1:0] recip;
    logic [MUL_A_W-1:0] den;
    logic [COORD_W-1:0] q_est;
    logic [COORD_W-1:0] quot;

    logic               accept;
    logic [IDX_W-1:0]   i_sel;
    logic [11:0]        i3;
    logic [11:0]        r3;

    assign accept = in_valid && in_ready;
    assign i3 = 12'(i_reg) * 12'd3;
    assign r3 = 12'(r_reg) * 12'd3;

    assign div_num   = (step_reg == 5'd15) ? accy_reg : accx_reg;
    assign div_rem   = (state_reg == S_DONE) ? remy_reg : remx_reg;
    assign div_qbase = (state_reg == S_DONE) ? qey_reg : qex_reg;

    always_comb
    begin
        i_sel = restart ? '0 : step_index_reg;
        // an out-of-range step starts over at zero
        if (i_sel > STEPS_I)
        begin
            i_sel = '0;
        end
    end

    // operand schedule of the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            5'd0:
            begin
                op_a = MUL_A_W'(i_reg);
                op_b = MUL_B_W'(i_reg);
            end
            5'd1:
            begin
                op_a = MUL_A_W'(r_reg);
                op_b = MUL_B_W'(r_reg);
            end
            5'd2:
            begin
                op_a = MUL_A_W'(ii_reg);
                op_b = MUL_B_W'(i_reg);
            end
            5'd3:
            begin
                op_a = MUL_A_W'(rr_reg);
                op_b = MUL_B_W'(r_reg);
            end
            5'd4:
            begin
                op_a = MUL_A_W'(ii_reg);
                op_b = MUL_B_W'(r3);
            end
            5'd5:
            begin
                op_a = MUL_A_W'(rr_reg);
                op_b = MUL_B_W'(i3);
            end
            5'd6:
            begin
                op_a = w0_reg;
                op_b = cfg_reg[REG_START_X];
            end
            5'd7:
            begin
                op_a = w0_reg;
                op_b = cfg_reg[REG_START_Y];
            end
            5'd8:
            begin
                op_a = w1_reg;
                op_b = cfg_reg[REG_CTRL1_X];
            end
            5'd9:
            begin
                op_a = w1_reg;
                op_b = cfg_reg[REG_CTRL1_Y];
            end
            5'd10:
            begin
                op_a = w2_reg;
                op_b = cfg_reg[REG_CTRL2_X];
            end
            5'd11:
            begin
                op_a = w2_reg;
                op_b = cfg_reg[REG_CTRL2_Y];
            end
            5'd12:
            begin
                op_a = w3_reg;
                op_b = cfg_reg[REG_END_X];
            end
            5'd13:
            begin
                op_a = w3_reg;
                op_b = cfg_reg[REG_END_Y];
            end
            // quotient estimates by the reciprocal, then their products with steps cubed
            5'd14, 5'd15:
            begin
                op_a = num_hi;
                op_b = recip;
            end
            5'd16:
            begin
                op_a = den;
                op_b = qex_reg;
            end
            5'd17:
            begin
                op_a = den;
                op_b = qey_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        step_index_next = step_index_reg;
        i_next          = i_reg;
        r_next          = r_reg;
        last_next       = last_reg;
        ii_next         = ii_reg;
        rr_next         = rr_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        w2_next         = w2_reg;
        w3_next         = w3_reg;
        accx_next       = accx_reg;
        accy_next       = accy_reg;
        qex_next        = qex_reg;
        qey_next        = qey_reg;
        remx_next       = remx_reg;
        remy_next       = remy_reg;
        qx_next         = qx_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        plast_next      = plast_reg;
        ovalid_next     = ovalid_reg;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    i_next          = i_sel;
                    r_next          = STEPS_I - i_sel;
                    last_next       = (i_sel == STEPS_I);
                    step_index_next = (i_sel == STEPS_I) ? '0 : i_sel + IDX_W'(1);
                    accx_next       = '0;
                    accy_next       = '0;
                    step_next       = '0;
                    state_next      = S_CALC;
                end
            end
            S_CALC:
            begin
                // prod holds the registered result of the operands issued at the previous step
                unique case (step_reg)
                    5'd1:    ii_next   = prod[19:0];
                    5'd2:    rr_next   = prod[19:0];
                    5'd3:    w3_next   = prod[MUL_A_W-1:0];
                    5'd4:    w0_next   = prod[MUL_A_W-1:0];
                    5'd5:    w2_next   = prod[MUL_A_W-1:0];
                    5'd6:    w1_next   = prod[MUL_A_W-1:0];
                    5'd15:   qex_next  = q_est;
                    5'd16:   qey_next  = q_est;
                    5'd17:   remx_next = accx_reg - prod;
                    5'd18:   remy_next = accy_reg - prod;
                    default: ;
                endcase
                if ((step_reg >= 5'd7) && (step_reg <= 5'd14))
                begin
                    if (step_reg[0])
                    begin
                        accx_next = accx_reg + prod;
                    end
                    else
                    begin
                        accy_next = accy_reg + prod;
                    end
                end
                if (step_reg == STEP_LAST)
                begin
                    qx_next    = quot;
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_DONE:
            begin
                // hold here until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    px_next     = qx_reg;
                    py_next     = quot;
                    plast_next  = last_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_REGS; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            step_index_reg <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            step_index_reg <= step_index_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        r_reg     <= r_next;
        last_reg  <= last_next;
        ii_reg    <= ii_next;
        rr_reg    <= rr_next;
        w0_reg    <= w0_next;
        w1_reg    <= w1_next;
        w2_reg    <= w2_next;
        w3_reg    <= w3_next;
        accx_reg  <= accx_next;
        accy_reg  <= accy_next;
        qex_reg   <= qex_next;
        qey_reg   <= qey_next;
        remx_reg  <= remx_next;
        remy_reg  <= remy_next;
        qx_reg    <= qx_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        plast_reg <= plast_next;
    end

    bcpg_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    bcpg_div #(.STEPS(STEPS)) u_div
    (
        .num    (div_num),
        .prod   (prod),
        .rem    (div_rem),
        .q_base (div_qbase),
        .num_hi (num_hi),
        .recip  (recip),
        .den    (den),
        .q_est  (q_est),
        .quot   (quot)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ovalid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = plast_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_index_reg <= STEPS_I)
        else $error("step index past the last step");

    a_accept_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CALC) && (step_reg == 5'd0))
        else $error("input beat did not start the multiply schedule");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(point_x) && $stable(point_y)
            && $stable(last_point))
        else $error("output beat changed while waiting");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!ovalid_reg || out_ready)) |=> out_valid)
        else $error("finished point not loaded into the output register");

endmodule
